/* rtl/sus_pkg.sv */
package sus_pkg;

    // Request codes
    localparam logic [2:0] REQ_INSERT   = 3'd0;
    localparam logic [2:0] REQ_POP      = 3'd1;
    localparam logic [2:0] REQ_DELETE   = 3'd2;
    localparam logic [2:0] REQ_CONTAINS = 3'd3;
    localparam logic [2:0] REQ_CLEAR    = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // Update command broadcast to every cell
    typedef enum logic [2:0] {
        CMD_HOLD   = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_POP    = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    // Broadcast control: compare strobe, update command, request value
    typedef struct packed {
        logic               cmp;
        t_cmd               cmd;
        logic signed [31:0] val;
    } t_cell_ctl;

    // What a cell shows to its neighbors
    typedef struct packed {
        logic signed [31:0] val;
        logic               vld;
        logic               lt;
    } t_link;

endpackage

/* rtl/sus_cell.sv */
module sus_cell
    import sus_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_link     i_left,
    input  t_link     i_right,
    output t_link     o_link,
    output logic      o_eq
);

    logic signed [31:0] r_val, n_val;
    logic               r_vld, n_vld;
    logic               r_lt, n_lt;
    logic               r_eq, n_eq;

    // Compare, then shift or load according to the broadcast command
    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        n_lt  = r_lt;
        n_eq  = r_eq;
        if (i_ctl.cmp) begin
            n_lt = r_vld && (r_val < i_ctl.val);
            n_eq = r_vld && (r_val == i_ctl.val);
        end
        case (i_ctl.cmd)
            CMD_INSERT: begin
                // cells at or after the insert slot move one place right
                if (!r_lt) begin
                    if (i_left.lt) begin
                        n_val = i_ctl.val;
                        n_vld = 1'b1;
                    end else begin
                        n_val = i_left.val;
                        n_vld = i_left.vld;
                    end
                end
            end
            CMD_DELETE: begin
                if (!r_lt) begin
                    n_val = i_right.val;
                    n_vld = i_right.vld;
                end
            end
            CMD_POP: begin
                n_val = i_right.val;
                n_vld = i_right.vld;
            end
            CMD_CLEAR: begin
                n_vld = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_val <= n_val;
        r_lt  <= n_lt;
        r_eq  <= n_eq;
    end

    assign o_link = '{val: r_val, vld: r_vld, lt: r_lt};
    assign o_eq   = r_eq;

    // Valid entries form a prefix of the chain
    a_vld_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_right.vld |-> r_vld)
        else $error("valid entry after an empty cell");

    // Neighboring entries are strictly ascending
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && i_right.vld) |-> (r_val < i_right.val))
        else $error("entries out of order");

endmodule

/* rtl/sorted_unique_set_top.sv */
// Requests pass through the accept, compare and apply steps; the result is registered
// out of the apply step, and no new request is taken until the block is idle again.
// The cell row compares in the compare step and shifts in the apply step.
// A stalled output holds the block in the apply step until taken.
// Reset (synchronous, active low) empties the set and drops any pending result.
module sorted_unique_set_top
    import sus_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_req_type,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic               o_found,
    output logic signed [31:0] o_popped_value
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CMP   = 3'b010,
        ST_APPLY = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [2:0]         r_req_type;
    logic signed [31:0] r_value;
    logic               r_out_valid, n_out_valid;
    logic [1:0]         r_status, n_status;
    logic               r_found, n_found;
    logic signed [31:0] r_popped, n_popped;

    t_cell_ctl          w_ctl;
    t_link              w_link [0:CAPACITY+1];
    logic [CAPACITY-1:0] w_eq;
    logic               w_hit;
    logic               w_full;
    logic               w_fire;

    // Chain boundaries: left end marks the insert slot, right end is empty
    assign w_link[0]          = '{val: '0, vld: 1'b0, lt: 1'b1};
    assign w_link[CAPACITY+1] = '{val: '0, vld: 1'b0, lt: 1'b0};

    // Row of cells
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        sus_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_left  (w_link[gi]),
            .i_right (w_link[gi+2]),
            .o_link  (w_link[gi+1]),
            .o_eq    (w_eq[gi])
        );
    end

    assign w_hit  = |w_eq;
    assign w_full = w_link[CAPACITY].vld;
    assign w_fire = (r_state == ST_APPLY) && (!r_out_valid || i_out_ready);

    // Sequencer, command decode and result formation
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_found     = r_found;
        n_popped    = r_popped;
        w_ctl.cmp   = (r_state == ST_CMP);
        w_ctl.cmd   = CMD_HOLD;
        w_ctl.val   = r_value;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                n_state = ST_APPLY;
            end
            ST_APPLY: begin
                if (w_fire) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_found     = 1'b0;
                    n_popped    = '0;
                    case (r_req_type)
                        REQ_INSERT: begin
                            if (!w_hit) begin
                                if (w_full) begin
                                    n_status = ST_FULL;
                                end else begin
                                    w_ctl.cmd = CMD_INSERT;
                                end
                            end
                        end
                        REQ_POP: begin
                            if (!w_link[1].vld) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_popped  = w_link[1].val;
                                w_ctl.cmd = CMD_POP;
                            end
                        end
                        REQ_DELETE: begin
                            if (!w_hit) begin
                                n_status = ST_NOTFOUND;
                            end else begin
                                w_ctl.cmd = CMD_DELETE;
                            end
                        end
                        REQ_CONTAINS: begin
                            n_found = w_hit;
                        end
                        REQ_CLEAR: begin
                            w_ctl.cmd = CMD_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        if (r_state == ST_IDLE && i_in_valid) begin
            r_req_type <= i_req_type;
            r_value    <= i_value;
        end
        r_status <= n_status;
        r_found  <= n_found;
        r_popped <= n_popped;
    end

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_found        = r_found;
    assign o_popped_value = r_popped;

    // A new result only appears out of the apply step
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_APPLY))
        else $error("result raised outside apply step");

    // The compare step is always followed directly by the apply step
    a_cmp_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |=> (r_state == ST_APPLY))
        else $error("compare step did not advance");

    // A full status is only reported while the last cell is occupied
    a_full_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid) && r_status == ST_FULL) |-> w_full)
        else $error("full reported with free capacity");

endmodule
